// ===== hdl/epmc_pkg.sv =====
// Shared types and constants for the exact pattern match counter.
// No dependencies; used by epmc_window_cmp and exact_pattern_match_counter.
`default_nettype none

package epmc_pkg;

    localparam int BYTE_W          = 8;
    localparam int PAT_BYTES       = 32;
    localparam int PAT_IDX_W       = $clog2(PAT_BYTES);
    localparam int LEN_W           = 6;
    localparam int MIN_PATTERN     = 2;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int COUNT_W         = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int PAT_WORDS       = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/epmc_window_cmp.sv =====
// Parallel compare of the byte window against the pattern for one text byte.
// Depends on epmc_pkg.
`default_nettype none

module epmc_window_cmp #(
    parameter int MAX_PATTERN = epmc_pkg::MAX_PATTERN_DEF
) (
    input  wire logic [MAX_PATTERN-1:0][epmc_pkg::BYTE_W-1:0]         window,
    input  wire logic [epmc_pkg::PAT_BYTES-1:0][epmc_pkg::BYTE_W-1:0] pat_bytes,
    input  wire logic [epmc_pkg::LEN_W-1:0]                           len_eff,
    input  wire logic [$clog2(MAX_PATTERN+1)-1:0]                     seen,
    output logic                                                      hit
);
    import epmc_pkg::*;

    logic [PAT_IDX_W-1:0]   tap_idx [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] lane_ok;

    // Window entry k (newest is 0) lines up with pattern byte len-1-k.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            tap_idx[k] = PAT_IDX_W'(len_eff - LEN_W'(k) - LEN_W'(1));
            lane_ok[k] = (LEN_W'(k) >= len_eff) ||
                         (window[k] == pat_bytes[tap_idx[k]]);
        end
        hit = (LEN_W'(seen) >= len_eff) && (&lane_ok);
    end

endmodule

`default_nettype wire

// ===== hdl/exact_pattern_match_counter.sv =====
// Top level of the exact pattern match counter: handshakes, state and result register.
// Depends on epmc_pkg and epmc_window_cmp.
`default_nettype none

// Counts every occurrence, overlaps included, of a configured byte pattern
// (2 to MAX_PATTERN bytes) in a text that streams in one byte per input word.
// Each accepted byte yields exactly one result word: whether an occurrence ends
// at that byte, the saturating count of occurrences so far in the current text,
// and a copy of the final-byte flag. After the final byte the fill count and
// the count are cleared, so the next word starts a new text. The block takes
// one byte per clock cycle, sustained while the result side takes its words;
// the byte is caught in the input register when it is accepted and moves into
// the result register once that register is empty or its word is being taken.
// The whole window is compared against the pattern combinationally between them.
// Configuration writes (pattern length and four 64-bit pattern words, byte 0 in
// the low bits) are always taken and must be done while no text byte is in
// flight; indexes beyond the register list are ignored.
module exact_pattern_match_counter #(
    parameter int MAX_PATTERN = epmc_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [epmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [epmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Text input channel.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [epmc_pkg::BYTE_W-1:0]        s_text_byte,
    input  wire logic                               s_final_byte,
    // Result channel.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_match_end,
    output logic [epmc_pkg::COUNT_W-1:0]            m_occurrence_count,
    output logic                                    m_text_done
);
    import epmc_pkg::*;

    localparam int SEEN_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers.
    logic [LEN_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_word_reg [PAT_WORDS];

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_final_reg;

    // Text state. The window holds the newest byte at entry 0.
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_next;
    logic [SEEN_W-1:0]                  seen_reg;
    logic [SEEN_W-1:0]                  seen_next;
    logic [COUNT_W-1:0]                 count_reg;
    logic [COUNT_W-1:0]                 count_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_match_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_done_reg;

    logic                                  advance;
    logic                                  hit;
    logic [LEN_W-1:0]                      len_eff;
    logic [PAT_BYTES-1:0][BYTE_W-1:0]      pat_bytes;
    logic [COUNT_W-1:0]                    count_step;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always accepted.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(MIN_PATTERN);
            for (int w = 0; w < PAT_WORDS; w++) begin
                pattern_word_reg[w] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: pattern_length_reg  <= cfg_data[LEN_W-1:0];
                REG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_data;
                REG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_data;
                REG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_data;
                REG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pattern bytes in order, byte 0 from the low bits of word 0.
    assign pat_bytes = {pattern_word_reg[3], pattern_word_reg[2],
                        pattern_word_reg[1], pattern_word_reg[0]};

    // Out-of-range lengths are clamped to the supported range.
    always_comb begin
        priority if (pattern_length_reg < LEN_W'(MIN_PATTERN)) begin
            len_eff = LEN_W'(MIN_PATTERN);
        end else if (pattern_length_reg > LEN_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = pattern_length_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes. The input register moves into the result register when
    // that register is empty or its word is being taken, so a new byte can
    // be accepted in every cycle while results drain.
    // ------------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_text_byte;
            in_final_reg <= s_final_byte;
        end
    end

    // ------------------------------------------------------------------
    // Per-byte work: shift the byte into the window, bump the fill count,
    // compare, and update the saturating count.
    // ------------------------------------------------------------------
    always_comb begin
        window_next[0] = in_byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    assign seen_next = (seen_reg == SEEN_W'(MAX_PATTERN)) ? seen_reg : seen_reg + SEEN_W'(1);

    epmc_window_cmp #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_cmp (
        .window   (window_next),
        .pat_bytes(pat_bytes),
        .len_eff  (len_eff),
        .seen     (seen_next),
        .hit      (hit)
    );

    assign count_step = (hit && (count_reg != '1)) ? count_reg + COUNT_W'(1) : count_reg;

    // A final byte clears the fill count and the count for the next text.
    // The window itself needs no clearing: a match is only reported once
    // the fill count shows that every compared entry belongs to this text.
    always_comb begin
        count_next = in_final_reg ? '0 : count_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            count_reg <= '0;
        end else if (advance) begin
            seen_reg  <= in_final_reg ? '0 : seen_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            window_reg <= window_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_match_reg <= hit;
            out_count_reg <= count_step;
            out_done_reg  <= in_final_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_match_end        = out_match_reg;
    assign m_occurrence_count = out_count_reg;
    assign m_text_done        = out_done_reg;

`ifndef SYNTHESIS
    // A reported occurrence is always counted.
    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_end |-> m_occurrence_count != '0)
        else $error("match reported with a zero count");

    // After a final byte moves on, the next text starts from a clean state.
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_final_reg |=> seen_reg == '0 && count_reg == '0)
        else $error("state not cleared after the final byte");

    // The fill count saturates at the window depth.
    a_seen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SEEN_W'(MAX_PATTERN))
        else $error("fill count beyond the window depth");

    // An empty input register always takes a new word.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while the input register is empty");
`endif

endmodule

`default_nettype wire

// ===== tb/epmc_match_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the exact pattern match counter: mirrors register writes, predicts
// one result word per accepted text byte and compares the result words in order.
// Depends on epmc_pkg.
module epmc_match_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [epmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [epmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire logic [epmc_pkg::BYTE_W-1:0]      s_text_byte,
    input  wire logic                             s_final_byte,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire logic                             m_match_end,
    input  wire logic [epmc_pkg::COUNT_W-1:0]     m_occurrence_count,
    input  wire logic                             m_text_done,
    output int unsigned                           fail_count,
    output int unsigned                           pending
);
    import epmc_pkg::*;

    typedef struct packed {
        logic               match_end;
        logic [COUNT_W-1:0] occurrence_count;
        logic               text_done;
    } match_word_t;

    logic [LEN_W-1:0]            length_code;
    logic [PAT_BYTES*BYTE_W-1:0] pattern_bits;
    logic [BYTE_W-1:0]           window [MAX_PATTERN_DEF];
    int                          fill;
    logic [COUNT_W-1:0]          running;
    match_word_t                 awaited_words [$];
    match_word_t                 due_word;
    int unsigned                 errors = 0;

    assign fail_count = errors;

    task automatic clear_text();
        for (int i = 0; i < MAX_PATTERN_DEF; i++) window[i] = '0;
        fill = 0;
        running = '0;
    endtask

    // Shifts one byte into the window, reports whether the pattern ends here and updates the running count.
    task automatic score_byte(input logic [BYTE_W-1:0] b, input logic last,
                              output match_word_t w);
        int   span;
        logic hit;
        if (length_code < MIN_PATTERN) span = MIN_PATTERN;
        else if (length_code > MAX_PATTERN_DEF) span = MAX_PATTERN_DEF;
        else span = int'(length_code);
        for (int i = MAX_PATTERN_DEF - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = b;
        if (fill < MAX_PATTERN_DEF) fill++;
        hit = (fill >= span);
        for (int i = 0; i < span; i++) begin
            if (window[span - 1 - i] != pattern_bits[i*BYTE_W +: BYTE_W]) hit = 1'b0;
        end
        if (hit && running != '1) running++;
        w.match_end = hit;
        w.occurrence_count = running;
        w.text_done = last;
        if (last) clear_text();
    endtask

    task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            length_code = LEN_W'(MIN_PATTERN);
            pattern_bits = '0;
            clear_text();
            awaited_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    $display("%0t ns: result word expected none, actual count %0h",
                             $time, m_occurrence_count);
                    errors++;
                end else begin
                    due_word = awaited_words.pop_front();
                    check_field("match_end", due_word.match_end, m_match_end);
                    check_field("occurrence_count", due_word.occurrence_count,
                                m_occurrence_count);
                    check_field("text_done", due_word.text_done, m_text_done);
                end
            end
            if (s_valid && s_ready) begin
                score_byte(s_text_byte, s_final_byte, due_word);
                awaited_words.push_back(due_word);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PATTERN_LENGTH: length_code = cfg_data[LEN_W-1:0];
                    REG_PATTERN_WORD_0, REG_PATTERN_WORD_1,
                    REG_PATTERN_WORD_2, REG_PATTERN_WORD_3: begin
                        pattern_bits[(int'(cfg_index) - int'(REG_PATTERN_WORD_0))
                                     * CFG_DATA_W +: CFG_DATA_W] = cfg_data;
                    end
                    default: ;
                endcase
            end
        end
        pending <= awaited_words.size();
    end

endmodule

// ===== tb/tb_exact_pattern_match_counter.sv =====
`timescale 1ns / 100ps
// Top of the exact pattern match counter testbench: clock, reset, stimulus and verdict.
// Depends on epmc_pkg, exact_pattern_match_counter and epmc_match_checker.
module tb_exact_pattern_match_counter;
    import epmc_pkg::*;

    localparam int ITEM_TARGET     = 1550;
    // Room left after the checker reports no pending result word.
    localparam int SETTLE_CYCLES   = 8;
    localparam int FIRST_SPARE_REG = int'(REG_PATTERN_WORD_3) + 1;
    localparam int LAST_SPARE_REG  = (1 << CFG_INDEX_W) - 1;

    // Receiver behaviors; the result side switches among them at random.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_CADENCE
    } ready_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_text_byte = '0;
    logic                   s_final_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_match_end;
    logic [COUNT_W-1:0]     m_occurrence_count;
    logic                   m_text_done;

    int unsigned            fail_count;
    int unsigned            pending;
    int                     sent_count = 0;
    int                     burst_left = 0;
    logic [BYTE_W-1:0]      text_q [$];
    ready_mode_t            ready_mode = READY_ALWAYS;
    int                     ready_left = 0;
    int                     ready_phase = 0;

    always #2 aclk = ~aclk;

    exact_pattern_match_counter #(
        .MAX_PATTERN(MAX_PATTERN_DEF)
    ) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_text_byte        (s_text_byte),
        .s_final_byte       (s_final_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_match_end        (m_match_end),
        .m_occurrence_count (m_occurrence_count),
        .m_text_done        (m_text_done)
    );

    epmc_match_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_text_byte        (s_text_byte),
        .s_final_byte       (s_final_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_match_end        (m_match_end),
        .m_occurrence_count (m_occurrence_count),
        .m_text_done        (m_text_done),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    // The result side picks a new stall behavior every so often, so that back
    // pressure lands on every phase of the sender's bursts and gaps.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 300);
        end else begin
            ready_left = ready_left - 1;
        end
        ready_phase = ready_phase + 1;
        case (ready_mode)
            READY_ALWAYS:  m_ready <= 1'b1;
            READY_COIN:    m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  m_ready <= ($urandom_range(0, 5) == 0);
            default:       m_ready <= (ready_phase % 5) != 0;
        endcase
    end

    // Sends one text word. The sender runs in bursts; when a burst is used up it
    // drops valid for a random gap before the next burst, so valid is never lowered
    // and raised within the same edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 48);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_final_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left = burst_left - 1;
        sent_count = sent_count + 1;
    endtask

    // Sends the bytes held in text_q; the last one carries the final flag only
    // when the text is to be closed.
    task automatic send_text(input bit terminate);
        foreach (text_q[k]) begin
            send_byte(text_q[k], terminate && (k == text_q.size() - 1));
        end
    endtask

    // Valid stays high across a batch of writes; program_pattern lowers it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Writes the length and all four pattern words. The length write carries
    // random upper bits, which the block must drop. With spare set, a write to
    // an index past the register list follows, which the block must ignore.
    task automatic program_pattern(input logic [LEN_W-1:0] len_code,
                                   input logic [PAT_BYTES*BYTE_W-1:0] bits,
                                   input bit spare);
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom(), $urandom()};
        len_word[LEN_W-1:0] = len_code;
        write_reg(REG_PATTERN_LENGTH, len_word);
        for (int w = 0; w < PAT_WORDS; w++) begin
            write_reg(CFG_INDEX_W'(int'(REG_PATTERN_WORD_0) + w),
                      bits[w*CFG_DATA_W +: CFG_DATA_W]);
        end
        if (spare) begin
            write_reg(CFG_INDEX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
                      {$urandom(), $urandom()});
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops sending and waits until every predicted word has come back. The extra
    // edge first lets the checker count a byte accepted at this very edge.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [PAT_BYTES*BYTE_W-1:0] bits;
        logic [LEN_W-1:0]            len_code;
        logic [BYTE_W-1:0]           sym_a;
        logic [BYTE_W-1:0]           sym_b;
        int                          eff_len;
        int                          texts;
        int                          target;
        int                          kind;
        int                          cut;
        bit                          terminate;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The reset pattern is two zero bytes: it matches at once,
        // misses after 0xFF, and matches again on the final byte.
        text_q = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};
        send_text(1'b1);
        drain_results();

        // A length code of zero acts as two; an all-ones pattern against three
        // 0xFF bytes gives two overlapping occurrences.
        bits = '1;
        program_pattern(LEN_W'(0), bits, 1'b1);
        text_q = '{8'hFF, 8'hFF, 8'hFF};
        send_text(1'b1);
        drain_results();

        // A three-byte pattern: a text shorter than the pattern never matches.
        bits = '0;
        bits[0 +: 24] = 24'h434241;
        program_pattern(LEN_W'(3), bits, 1'b0);
        text_q = '{8'h41, 8'h42};
        send_text(1'b1);
        drain_results();

        // Leave a text open, then switch the pattern under it: a length code of
        // one acts as two, and the new pattern sees the old window on the next byte.
        text_q = '{8'h5A, 8'h41, 8'h42};
        send_text(1'b0);
        drain_results();
        bits = '0;
        bits[0 +: 16] = 16'h4342;
        program_pattern(LEN_W'(1), bits, 1'b1);
        text_q = '{8'h43};
        send_text(1'b1);
        drain_results();

        // Random part. Each phase programs a pattern, mostly short and drawn from a
        // two-symbol alphabet so that texts built from whole copies, prefixes and
        // stray symbols give frequent and overlapping occurrences. Out-of-range and
        // maximum lengths show up regularly. A phase's last text is sometimes left
        // open, so the next pattern takes over in the middle of a text.
        while (sent_count < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       len_code = LEN_W'($urandom_range(0, MIN_PATTERN - 1));
                1:       len_code = LEN_W'($urandom_range(MAX_PATTERN_DEF + 1,
                                                          (1 << LEN_W) - 1));
                2:       len_code = LEN_W'(MAX_PATTERN_DEF);
                3:       len_code = LEN_W'($urandom_range(7, MAX_PATTERN_DEF - 1));
                default: len_code = LEN_W'($urandom_range(MIN_PATTERN, 6));
            endcase
            if (len_code < MIN_PATTERN) eff_len = MIN_PATTERN;
            else if (len_code > MAX_PATTERN_DEF) eff_len = MAX_PATTERN_DEF;
            else eff_len = int'(len_code);

            if ($urandom_range(0, 3) == 0) begin
                sym_a = 8'h00;
                sym_b = 8'hFF;
            end else begin
                sym_a = BYTE_W'($urandom_range(0, 255));
                sym_b = BYTE_W'($urandom_range(0, 255));
            end
            // Bytes past the active length are random; the block must not look at them.
            for (int i = 0; i < PAT_BYTES; i++) begin
                if (i < eff_len && $urandom_range(0, 4) != 0)
                    bits[i*BYTE_W +: BYTE_W] = $urandom_range(0, 1) ? sym_a : sym_b;
                else
                    bits[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
            end
            program_pattern(len_code, bits, $urandom_range(0, 3) == 0);

            texts = $urandom_range(1, 4);
            for (int t = 0; t < texts; t++) begin
                text_q.delete();
                target = $urandom_range(1, 3 * eff_len + 4);
                while (text_q.size() < target) begin
                    kind = $urandom_range(0, 9);
                    if (kind < 4) cut = eff_len;
                    else if (kind < 6) cut = $urandom_range(1, eff_len - 1);
                    else cut = 0;
                    for (int i = 0; i < cut; i++) text_q.push_back(bits[i*BYTE_W +: BYTE_W]);
                    if (kind >= 6 && kind < 9)
                        text_q.push_back($urandom_range(0, 1) ? sym_a : sym_b);
                    if (kind == 9) text_q.push_back(BYTE_W'($urandom_range(0, 255)));
                end
                terminate = (t < texts - 1) || ($urandom_range(0, 3) != 0);
                send_text(terminate);
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
